// ===== hw/rtl/rgbw_pkg.sv =====
// ---------------------------------------------------------------------------
// rgbw_pkg: shared types and codes for the RGBW lamp fade controller
// Lamp modes, item kinds, command codes, register indexes and status codes.
// ---------------------------------------------------------------------------
package rgbw_pkg;

    // Lamp mode, one-hot
    typedef enum logic [2:0] {
        MODE_OFF   = 3'b001,
        MODE_ON    = 3'b010,
        MODE_NIGHT = 3'b100
    } t_mode;

    typedef logic [7:0] t_level;

    // Reported lamp status codes
    localparam logic [1:0] STATUS_OFF   = 2'd0;
    localparam logic [1:0] STATUS_ON    = 2'd1;
    localparam logic [1:0] STATUS_NIGHT = 2'd2;

    // Item kinds (tuser)
    localparam logic [1:0] KIND_CMD        = 2'd0;
    localparam logic [1:0] KIND_NIGHT_TICK = 2'd1;
    localparam logic [1:0] KIND_FADE_TICK  = 2'd2;

    // Command codes
    localparam logic [7:0] CMD_TOGGLE     = 8'h01;
    localparam logic [7:0] CMD_ON         = 8'h02;
    localparam logic [7:0] CMD_OFF        = 8'h03;
    localparam logic [7:0] CMD_UP         = 8'h10;
    localparam logic [7:0] CMD_DOWN       = 8'h20;
    localparam logic [7:0] CMD_SET        = 8'h22;
    localparam logic [7:0] CMD_TIMED_BASE = 8'h30;   // timed: strictly above

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_BRIGHT_STEP    = 2'd0;
    localparam logic [1:0] REG_BRIGHT_DEFAULT = 2'd1;
    localparam logic [1:0] REG_MAX_BRIGHT     = 2'd2;
    localparam logic [1:0] REG_MIN_BRIGHT     = 2'd3;

    // Register reset values
    localparam logic [6:0] BRIGHT_STEP_RST    = 7'd16;
    localparam logic [7:0] BRIGHT_DEFAULT_RST = 8'd128;
    localparam logic [7:0] MAX_BRIGHT_RST     = 8'd255;
    localparam logic [7:0] MIN_BRIGHT_RST     = 8'd0;

    // Colour thresholds
    localparam logic [7:0] WHITE_MIN  = 8'hF0;
    localparam logic [7:0] FULL_LEVEL = 8'hFF;
    localparam logic [7:0] LEVEL_CEIL = 8'hEF;   // colour clamp is this minus step

endpackage

// ===== hw/rtl/rgbw_lamp_fade_controller_top.sv =====
// ---------------------------------------------------------------------------
// rgbw_lamp_fade_controller_top: RGBW lamp controller with fades
// Path: the input register feeds the result register, which drives m_axis.
// Throughput: one request per cycle while m_axis is not stalled; the whole
//   state update (decode, retarget, clamp, fade step) is one combinational
//   pass between the input register and the result/state registers.
// Reset: synchronous, active low; clears both valid flags, sets the lamp off,
//   all levels and colour to zero, brightness and registers to reset values.
// ---------------------------------------------------------------------------
module rgbw_lamp_fade_controller_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] command, [15:8] red_in, [23:16] green_in, [31:24] blue_in
    input  logic [31:0] s_axis_tdata,
    // [1:0] kind
    input  logic [1:0]  s_axis_tuser,
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [1:0] lamp_status, [11:2] red_drive, [21:12] green_drive,
    // [31:22] blue_drive, [41:32] white_drive, [42] changed, [43] fading,
    // [51:44] level_now, [55:52] zero
    output logic [55:0] m_axis_tdata,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // ---------------- configuration registers ----------------
    logic [6:0] r_bright_step;
    logic [7:0] r_bright_default;
    logic [7:0] r_max_bright;
    logic [7:0] r_min_bright;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bright_step    <= rgbw_pkg::BRIGHT_STEP_RST;
            r_bright_default <= rgbw_pkg::BRIGHT_DEFAULT_RST;
            r_max_bright     <= rgbw_pkg::MAX_BRIGHT_RST;
            r_min_bright     <= rgbw_pkg::MIN_BRIGHT_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                rgbw_pkg::REG_BRIGHT_STEP:    r_bright_step    <= pwdata[6:0];
                rgbw_pkg::REG_BRIGHT_DEFAULT: r_bright_default <= pwdata[7:0];
                rgbw_pkg::REG_MAX_BRIGHT:     r_max_bright     <= pwdata[7:0];
                rgbw_pkg::REG_MIN_BRIGHT:     r_min_bright     <= pwdata[7:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            rgbw_pkg::REG_BRIGHT_STEP:    prdata = {25'd0, r_bright_step};
            rgbw_pkg::REG_BRIGHT_DEFAULT: prdata = {24'd0, r_bright_default};
            rgbw_pkg::REG_MAX_BRIGHT:     prdata = {24'd0, r_max_bright};
            rgbw_pkg::REG_MIN_BRIGHT:     prdata = {24'd0, r_min_bright};
        endcase
    end

    // ---------------- handshake ----------------
    // The input register advances into the result register whenever the
    // result register is empty or being drained, so a request can enter
    // every cycle while the result side is not stalled.
    logic r_in_vld;
    logic r_out_vld;
    logic advance;

    assign advance       = r_in_vld & (~r_out_vld | m_axis_tready);
    assign s_axis_tready = ~r_in_vld | advance;
    assign m_axis_tvalid = r_out_vld;

    // ---------------- input register ----------------
    logic [1:0]       r_in_kind;
    logic [7:0]       r_in_cmd;
    rgbw_pkg::t_level r_in_col [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_kind   <= s_axis_tuser;
            r_in_cmd    <= s_axis_tdata[7:0];
            r_in_col[0] <= s_axis_tdata[15:8];
            r_in_col[1] <= s_axis_tdata[23:16];
            r_in_col[2] <= s_axis_tdata[31:24];
        end
    end

    // ---------------- lamp state ----------------
    rgbw_pkg::t_mode  r_mode,   n_mode;
    rgbw_pkg::t_level r_col [3], n_col [3];
    rgbw_pkg::t_level r_bright, n_bright;
    rgbw_pkg::t_level r_tgt [4], n_tgt [4];
    rgbw_pkg::t_level r_cur [4], n_cur [4];
    logic             n_changed;
    logic             n_fading;

    // ---------------- next-state pass ----------------
    logic             go_on, go_off, go_up, go_down, go_set, go_night, go_fade;
    logic             do_apply;
    logic             up_ok, down_ok;
    logic [8:0]       min_plus_step;
    logic             apply_white;
    rgbw_pkg::t_level apply_max;
    logic signed [10:0] clamp_hi;
    logic signed [10:0] lvl_raw [3];
    logic             set_white;
    rgbw_pkg::t_level set_max;

    always_comb begin
        // decode into one action
        go_on    = 1'b0;
        go_off   = 1'b0;
        go_up    = 1'b0;
        go_down  = 1'b0;
        go_set   = 1'b0;
        go_night = 1'b0;
        go_fade  = 1'b0;

        min_plus_step = {1'b0, r_min_bright} + {2'b00, r_bright_step};
        up_ok   = ({1'b0, r_bright} + {2'b00, r_bright_step}) < {1'b0, r_max_bright};
        down_ok = {1'b0, r_bright} > min_plus_step;

        unique case (r_in_kind)
            rgbw_pkg::KIND_CMD: begin
                unique case (r_in_cmd)
                    rgbw_pkg::CMD_TOGGLE: begin
                        go_on  = (r_mode == rgbw_pkg::MODE_OFF);
                        go_off = (r_mode == rgbw_pkg::MODE_ON);
                    end
                    rgbw_pkg::CMD_ON:   go_on   = 1'b1;
                    rgbw_pkg::CMD_OFF:  go_off  = 1'b1;
                    rgbw_pkg::CMD_UP:   go_up   = 1'b1;
                    rgbw_pkg::CMD_DOWN: go_down = 1'b1;
                    rgbw_pkg::CMD_SET:  go_set  = 1'b1;
                    default:            go_night = (r_in_cmd > rgbw_pkg::CMD_TIMED_BASE);
                endcase
            end
            rgbw_pkg::KIND_NIGHT_TICK: begin
                // good-night tick: dim one step, or switch off at the floor
                if (r_mode == rgbw_pkg::MODE_NIGHT) begin
                    go_off  = ~down_ok;
                    go_down = down_ok;
                end
            end
            rgbw_pkg::KIND_FADE_TICK: go_fade = 1'b1;
            default: ;
        endcase

        // defaults: hold state
        n_mode   = r_mode;
        n_col    = r_col;
        n_bright = r_bright;
        n_tgt    = r_tgt;
        n_cur    = r_cur;
        do_apply = 1'b0;

        set_white = (r_in_col[0] >= rgbw_pkg::WHITE_MIN) &&
                    (r_in_col[1] >= rgbw_pkg::WHITE_MIN) &&
                    (r_in_col[2] >= rgbw_pkg::WHITE_MIN);
        set_max = r_in_col[0];
        if (r_in_col[1] > set_max) set_max = r_in_col[1];
        if (r_in_col[2] > set_max) set_max = r_in_col[2];

        if (go_on) begin
            n_mode = rgbw_pkg::MODE_ON;
            // switch-on with no colour: full white at default brightness
            if (r_col[0] == 8'd0 && r_col[1] == 8'd0 && r_col[2] == 8'd0) begin
                for (int i = 0; i < 3; i++) n_col[i] = rgbw_pkg::FULL_LEVEL;
                n_bright = r_bright_default;
            end
            do_apply = 1'b1;
        end
        if (go_off) begin
            n_mode = rgbw_pkg::MODE_OFF;
            for (int i = 0; i < 4; i++) n_tgt[i] = 8'd0;
        end
        if (go_up) begin
            if (up_ok) n_bright = r_bright + {1'b0, r_bright_step};
            do_apply = 1'b1;
        end
        if (go_down) begin
            if (down_ok) n_bright = r_bright - {1'b0, r_bright_step};
            do_apply = 1'b1;
        end
        if (go_set) begin
            // set jumps straight to its levels, no fade
            n_col  = r_in_col;
            n_mode = rgbw_pkg::MODE_ON;
            if (set_white) begin
                n_bright = r_bright_default;
                for (int i = 0; i < 3; i++) n_tgt[i] = 8'd0;
                n_tgt[3] = r_bright_default;
            end else begin
                n_bright = set_max;
                for (int i = 0; i < 3; i++) n_tgt[i] = r_in_col[i];
                n_tgt[3] = 8'd0;
            end
            n_cur = n_tgt;
        end
        if (go_night) begin
            n_mode = rgbw_pkg::MODE_NIGHT;
        end
        if (go_fade) begin
            for (int i = 0; i < 4; i++) begin
                if (r_cur[i] < r_tgt[i])      n_cur[i] = r_cur[i] + 8'd1;
                else if (r_cur[i] > r_tgt[i]) n_cur[i] = r_cur[i] - 8'd1;
            end
        end

        // retarget from colour and brightness after the action
        apply_white = (n_col[0] >= rgbw_pkg::WHITE_MIN) &&
                      (n_col[1] >= rgbw_pkg::WHITE_MIN) &&
                      (n_col[2] >= rgbw_pkg::WHITE_MIN);
        apply_max = n_col[0];
        if (n_col[1] > apply_max) apply_max = n_col[1];
        if (n_col[2] > apply_max) apply_max = n_col[2];
        clamp_hi = $signed({3'b000, rgbw_pkg::LEVEL_CEIL}) -
                   $signed({4'b0000, r_bright_step});
        for (int i = 0; i < 3; i++) begin
            lvl_raw[i] = $signed({3'b000, n_col[i]}) + $signed({3'b000, n_bright}) -
                         $signed({3'b000, apply_max});
        end

        if (do_apply) begin
            if (apply_white) begin
                // white only: colour channels drop at once
                for (int i = 0; i < 3; i++) begin
                    n_tgt[i] = 8'd0;
                    n_cur[i] = 8'd0;
                end
                n_tgt[3] = n_bright;
            end else begin
                n_tgt[3] = 8'd0;
                n_cur[3] = 8'd0;
                for (int i = 0; i < 3; i++) begin
                    if (lvl_raw[i] > clamp_hi)       n_tgt[i] = clamp_hi[7:0];
                    else if (lvl_raw[i] < 11'sd0)    n_tgt[i] = 8'd0;
                    else                             n_tgt[i] = lvl_raw[i][7:0];
                end
            end
        end

        n_changed = go_on | go_off;
        n_fading  = 1'b0;
        for (int i = 0; i < 4; i++) begin
            if (n_cur[i] != n_tgt[i]) n_fading = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= rgbw_pkg::MODE_OFF;
            r_bright <= rgbw_pkg::BRIGHT_DEFAULT_RST;
            for (int i = 0; i < 3; i++) r_col[i] <= 8'd0;
            for (int i = 0; i < 4; i++) begin
                r_tgt[i] <= 8'd0;
                r_cur[i] <= 8'd0;
            end
        end else if (advance) begin
            r_mode   <= n_mode;
            r_bright <= n_bright;
            r_col    <= n_col;
            r_tgt    <= n_tgt;
            r_cur    <= n_cur;
        end
    end

    // ---------------- result register ----------------
    logic [1:0]       r_out_status;
    logic [1:0]       n_status;
    rgbw_pkg::t_level r_out_cur [4];
    logic             r_out_changed;
    logic             r_out_fading;
    rgbw_pkg::t_level r_out_level;

    always_comb begin
        unique case (n_mode)
            rgbw_pkg::MODE_OFF:   n_status = rgbw_pkg::STATUS_OFF;
            rgbw_pkg::MODE_ON:    n_status = rgbw_pkg::STATUS_ON;
            rgbw_pkg::MODE_NIGHT: n_status = rgbw_pkg::STATUS_NIGHT;
            default:              n_status = rgbw_pkg::STATUS_OFF;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_status  <= n_status;
            r_out_cur     <= n_cur;
            r_out_changed <= n_changed;
            r_out_fading  <= n_fading;
            r_out_level   <= n_bright;
        end
    end

    // drive = level * 4
    assign m_axis_tdata = {4'b0000,
                           r_out_level,
                           r_out_fading,
                           r_out_changed,
                           r_out_cur[3], 2'b00,
                           r_out_cur[2], 2'b00,
                           r_out_cur[1], 2'b00,
                           r_out_cur[0], 2'b00,
                           r_out_status};

endmodule

// ===== hw/rtl/rgbw_chk.sv =====
// ---------------------------------------------------------------------------
// rgbw_chk: port-level checks for the RGBW lamp fade controller
// Watches the stream ports over time; attached to the top level by bind.
// ---------------------------------------------------------------------------
module rgbw_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata
);

    // stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // requests are refused only while the result side is stalled
    a_no_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(m_axis_tvalid && !m_axis_tready) |-> s_axis_tready)
        else $error("request refused with free result side");

    // white and colour channels never lit together
    a_white_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[41:32] != 10'd0) |->
        (m_axis_tdata[11:2] == 10'd0) && (m_axis_tdata[21:12] == 10'd0) &&
        (m_axis_tdata[31:22] == 10'd0))
        else $error("white and colour drive both nonzero");

    // an on/off transition never reports good-night status
    a_changed_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[42] |->
        m_axis_tdata[1:0] != rgbw_pkg::STATUS_NIGHT)
        else $error("changed flag with good-night status");

    // nothing offered right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind rgbw_lamp_fade_controller_top rgbw_chk u_rgbw_chk (.*);

// ===== tb/sv/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench: self-checking bench for rgbw_lamp_fade_controller_top
// Drives command, good-night and fade requests with random gaps and result
// back-pressure, predicts every result from a behavioral lamp model kept in
// step with the register settings, and compares each result field by field.
// ---------------------------------------------------------------------------
module testbench;

    // Codes the block has no name for but must ignore or treat as timed
    localparam logic [7:0] CMD_NONE        = 8'h00;
    localparam logic [7:0] CMD_FLASH       = 8'h21;
    localparam logic [7:0] CMD_TIMED_FIRST = 8'h31;
    localparam logic [7:0] CMD_TIMED_LAST  = 8'hFF;
    localparam logic [1:0] KIND_UNUSED     = 2'd3;

    // Result layout on m_axis_tdata, first member is the top bits
    typedef struct packed {
        logic [3:0] pad;
        logic [7:0] level_now;
        logic       fading;
        logic       changed;
        logic [9:0] white_drive;
        logic [9:0] blue_drive;
        logic [9:0] green_drive;
        logic [9:0] red_drive;
        logic [1:0] lamp_status;
    } t_lamp_result;

    // -----------------------------------------------------------------------
    // Clock, reset and DUT ports; every input starts at a known value
    // -----------------------------------------------------------------------
    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;   // [7:0] cmd, [15:8] r, [23:16] g, [31:24] b
    logic [1:0]  s_axis_tuser  = '0;   // [1:0] kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;         // see t_lamp_result
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [3:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    rgbw_lamp_fade_controller_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // -----------------------------------------------------------------------
    // Lamp model: register copies and lamp state
    // -----------------------------------------------------------------------
    logic [6:0]       cfg_step;
    rgbw_pkg::t_level cfg_default;
    rgbw_pkg::t_level cfg_max;
    rgbw_pkg::t_level cfg_min;

    rgbw_pkg::t_mode  lamp_mode;
    rgbw_pkg::t_level lamp_colour [3];     // r, g, b
    rgbw_pkg::t_level lamp_bright;
    rgbw_pkg::t_level level_target [4];    // r, g, b, w
    rgbw_pkg::t_level level_current [4];

    t_lamp_result expected_results [$];

    int fault_count   = 0;
    int results_seen  = 0;
    int requests_sent = 0;
    bit sender_eager   = 1'b0;     // no gaps between requests
    bit receiver_eager = 1'b0;     // no result stalls

    function automatic void lamp_model_reset();
        cfg_step    = rgbw_pkg::BRIGHT_STEP_RST;
        cfg_default = rgbw_pkg::BRIGHT_DEFAULT_RST;
        cfg_max     = rgbw_pkg::MAX_BRIGHT_RST;
        cfg_min     = rgbw_pkg::MIN_BRIGHT_RST;
        lamp_mode   = rgbw_pkg::MODE_OFF;
        lamp_bright = rgbw_pkg::BRIGHT_DEFAULT_RST;
        for (int i = 0; i < 3; i++) lamp_colour[i] = '0;
        for (int i = 0; i < 4; i++) begin
            level_target[i]  = '0;
            level_current[i] = '0;
        end
    endfunction

    function automatic bit colour_is_white();
        return lamp_colour[0] >= rgbw_pkg::WHITE_MIN &&
               lamp_colour[1] >= rgbw_pkg::WHITE_MIN &&
               lamp_colour[2] >= rgbw_pkg::WHITE_MIN;
    endfunction

    function automatic rgbw_pkg::t_level colour_peak();
        rgbw_pkg::t_level m;
        m = lamp_colour[0];
        if (lamp_colour[1] > m) m = lamp_colour[1];
        if (lamp_colour[2] > m) m = lamp_colour[2];
        return m;
    endfunction

    // New targets from colour and brightness; the idle channels snap to zero.
    function automatic void retarget_levels();
        int base;
        int ceiling;
        int v;
        if (colour_is_white()) begin
            for (int i = 0; i < 3; i++) begin
                level_target[i]  = '0;
                level_current[i] = '0;
            end
            level_target[3] = lamp_bright;
        end else begin
            base    = int'(colour_peak());
            ceiling = int'(rgbw_pkg::LEVEL_CEIL) - int'(cfg_step);
            level_target[3]  = '0;
            level_current[3] = '0;
            for (int i = 0; i < 3; i++) begin
                v = int'(lamp_colour[i]) + int'(lamp_bright) - base;
                if (v > ceiling) v = ceiling;
                else if (v < 0) v = 0;
                level_target[i] = rgbw_pkg::t_level'(v);
            end
        end
    endfunction

    function automatic void lamp_off();
        lamp_mode = rgbw_pkg::MODE_OFF;
        for (int i = 0; i < 4; i++) level_target[i] = '0;
    endfunction

    function automatic void lamp_on();
        lamp_mode = rgbw_pkg::MODE_ON;
        if (lamp_colour[0] == 8'd0 && lamp_colour[1] == 8'd0 &&
            lamp_colour[2] == 8'd0) begin
            for (int i = 0; i < 3; i++) lamp_colour[i] = rgbw_pkg::FULL_LEVEL;
            lamp_bright = cfg_default;
        end
        retarget_levels();
    endfunction

    function automatic void brighten();
        if (int'(lamp_bright) < int'(cfg_max) - int'(cfg_step))
            lamp_bright = lamp_bright + rgbw_pkg::t_level'(cfg_step);
        retarget_levels();
    endfunction

    function automatic void dim();
        if (int'(lamp_bright) > int'(cfg_min) + int'(cfg_step))
            lamp_bright = lamp_bright - rgbw_pkg::t_level'(cfg_step);
        retarget_levels();
    endfunction

    function automatic void load_colour(rgbw_pkg::t_level r, rgbw_pkg::t_level g,
                                        rgbw_pkg::t_level b);
        lamp_colour[0] = r;
        lamp_colour[1] = g;
        lamp_colour[2] = b;
        if (colour_is_white()) begin
            lamp_bright = cfg_default;
            for (int i = 0; i < 3; i++) level_target[i] = '0;
            level_target[3] = lamp_bright;
        end else begin
            lamp_bright = colour_peak();
            for (int i = 0; i < 3; i++) level_target[i] = lamp_colour[i];
            level_target[3] = '0;
        end
        for (int i = 0; i < 4; i++) level_current[i] = level_target[i];
        lamp_mode = rgbw_pkg::MODE_ON;
    endfunction

    // Advance the model by one request and return the result it must produce.
    function automatic t_lamp_result predict_lamp(logic [1:0] kind, logic [31:0] data);
        t_lamp_result res;
        logic [7:0]   cmd;
        logic         changed;
        logic         fading;
        cmd     = data[7:0];
        changed = 1'b0;
        fading  = 1'b0;
        case (kind)
            rgbw_pkg::KIND_CMD: begin
                if (cmd == rgbw_pkg::CMD_TOGGLE) begin
                    if (lamp_mode == rgbw_pkg::MODE_OFF) begin
                        lamp_on();
                        changed = 1'b1;
                    end else if (lamp_mode == rgbw_pkg::MODE_ON) begin
                        lamp_off();
                        changed = 1'b1;
                    end
                end else if (cmd == rgbw_pkg::CMD_ON) begin
                    lamp_on();
                    changed = 1'b1;
                end else if (cmd == rgbw_pkg::CMD_OFF) begin
                    lamp_off();
                    changed = 1'b1;
                end else if (cmd == rgbw_pkg::CMD_UP) begin
                    brighten();
                end else if (cmd == rgbw_pkg::CMD_DOWN) begin
                    dim();
                end else if (cmd == rgbw_pkg::CMD_SET) begin
                    load_colour(data[15:8], data[23:16], data[31:24]);
                end else if (cmd > rgbw_pkg::CMD_TIMED_BASE) begin
                    lamp_mode = rgbw_pkg::MODE_NIGHT;
                end
            end
            rgbw_pkg::KIND_NIGHT_TICK: begin
                if (lamp_mode == rgbw_pkg::MODE_NIGHT) begin
                    if (int'(lamp_bright) <= int'(cfg_min) + int'(cfg_step)) begin
                        lamp_off();
                        changed = 1'b1;
                    end else begin
                        dim();
                    end
                end
            end
            rgbw_pkg::KIND_FADE_TICK: begin
                for (int i = 0; i < 4; i++) begin
                    if (level_current[i] < level_target[i])
                        level_current[i] = level_current[i] + 8'd1;
                    else if (level_current[i] > level_target[i])
                        level_current[i] = level_current[i] - 8'd1;
                end
            end
            default: ;
        endcase
        for (int i = 0; i < 4; i++)
            if (level_current[i] != level_target[i]) fading = 1'b1;

        case (lamp_mode)
            rgbw_pkg::MODE_ON:    res.lamp_status = rgbw_pkg::STATUS_ON;
            rgbw_pkg::MODE_NIGHT: res.lamp_status = rgbw_pkg::STATUS_NIGHT;
            default:              res.lamp_status = rgbw_pkg::STATUS_OFF;
        endcase
        res.red_drive   = {level_current[0], 2'b00};
        res.green_drive = {level_current[1], 2'b00};
        res.blue_drive  = {level_current[2], 2'b00};
        res.white_drive = {level_current[3], 2'b00};
        res.changed     = changed;
        res.fading      = fading;
        res.level_now   = lamp_bright;
        res.pad         = '0;
        return res;
    endfunction

    // -----------------------------------------------------------------------
    // Mismatch reporting
    // -----------------------------------------------------------------------
    task automatic report_fault(string msg);
        fault_count++;
        $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    task automatic compare_field(string name, int got, int want);
        if (got != want)
            report_fault($sformatf("result %0d %s got %0d want %0d",
                                   results_seen, name, got, want));
    endtask

    // -----------------------------------------------------------------------
    // Predictor: every accepted request pushes one expected result.
    // Sampled at the edge, so values are the ones driven before it.
    // -----------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            expected_results.push_back(predict_lamp(s_axis_tuser, s_axis_tdata));
    end

    // -----------------------------------------------------------------------
    // Result checker: each accepted result against the oldest expectation
    // -----------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_lamp_result got;
        t_lamp_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_lamp_result'(m_axis_tdata);
            if (expected_results.size() == 0) begin
                report_fault($sformatf("unexpected result 0x%014h", m_axis_tdata));
            end else begin
                want = expected_results.pop_front();
                compare_field("lamp_status", int'(got.lamp_status), int'(want.lamp_status));
                compare_field("red_drive",   int'(got.red_drive),   int'(want.red_drive));
                compare_field("green_drive", int'(got.green_drive), int'(want.green_drive));
                compare_field("blue_drive",  int'(got.blue_drive),  int'(want.blue_drive));
                compare_field("white_drive", int'(got.white_drive), int'(want.white_drive));
                compare_field("changed",     int'(got.changed),     int'(want.changed));
                compare_field("fading",      int'(got.fading),      int'(want.fading));
                compare_field("level_now",   int'(got.level_now),   int'(want.level_now));
                compare_field("pad",         int'(got.pad),         int'(want.pad));
            end
            results_seen++;
        end
    end

    // -----------------------------------------------------------------------
    // Result sink: random stall before taking each result,
    // none while receiver_eager is set.
    // -----------------------------------------------------------------------
    initial begin
        int stall;
        forever begin
            stall = receiver_eager ? 0 : $urandom_range(0, 15);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(i_rst_n && m_axis_tvalid));
        end
    end

    // -----------------------------------------------------------------------
    // Request source: optional gap, then hold the request until accepted.
    // Called and returning on a rising edge; tvalid stays high across
    // back-to-back requests.
    // -----------------------------------------------------------------------
    task automatic send_request(logic [1:0] kind, logic [7:0] cmd, logic [23:0] bgr);
        int gap;
        gap = sender_eager ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tdata  <= {bgr, cmd};
        s_axis_tuser  <= kind;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        requests_sent++;
    endtask

    task automatic send_command(logic [7:0] cmd);
        send_request(rgbw_pkg::KIND_CMD, cmd, 24'($urandom));
    endtask

    task automatic send_colour(rgbw_pkg::t_level r, rgbw_pkg::t_level g,
                               rgbw_pkg::t_level b);
        send_request(rgbw_pkg::KIND_CMD, rgbw_pkg::CMD_SET, {b, g, r});
    endtask

    // Stop sending, wait for every outstanding result and let the pipeline settle.
    task automatic drain_results();
        int guard;
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        guard = 0;
        while (expected_results.size() != 0 && guard < 4000) begin
            @(posedge i_clk);
            guard++;
        end
        if (expected_results.size() != 0) begin
            report_fault($sformatf("%0d results never arrived", expected_results.size()));
            expected_results.delete();
        end
        repeat (4) @(posedge i_clk);
    endtask

    // -----------------------------------------------------------------------
    // Register port: setup + access, psel dropped after
    // -----------------------------------------------------------------------
    task automatic apb_access(logic wr, logic [1:0] idx, logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Write one register, mirror it in the model, and read it back.
    task automatic program_register(logic [1:0] idx, logic [7:0] value);
        logic [31:0] rd;
        logic [31:0] mask;
        apb_access(1'b1, idx, {24'd0, value}, rd);
        case (idx)
            rgbw_pkg::REG_BRIGHT_STEP:    cfg_step    = value[6:0];
            rgbw_pkg::REG_BRIGHT_DEFAULT: cfg_default = value;
            rgbw_pkg::REG_MAX_BRIGHT:     cfg_max     = value;
            default:                      cfg_min     = value;
        endcase
        mask = (idx == rgbw_pkg::REG_BRIGHT_STEP) ? 32'h7F : 32'hFF;
        apb_access(1'b0, idx, '0, rd);
        if ((rd & mask) != ({24'd0, value} & mask))
            report_fault($sformatf("register %0d read 0x%0h want 0x%0h",
                                   idx, rd & mask, value & mask));
    endtask

    task automatic program_all(logic [6:0] step, rgbw_pkg::t_level dflt,
                               rgbw_pkg::t_level maxb, rgbw_pkg::t_level minb);
        program_register(rgbw_pkg::REG_BRIGHT_STEP,    {1'b0, step});
        program_register(rgbw_pkg::REG_BRIGHT_DEFAULT, dflt);
        program_register(rgbw_pkg::REG_MAX_BRIGHT,     maxb);
        program_register(rgbw_pkg::REG_MIN_BRIGHT,     minb);
    endtask

    // -----------------------------------------------------------------------
    // Random content
    // -----------------------------------------------------------------------
    // Colours lean toward the white threshold, all-zero and single bright
    // channels so the white/colour split and the clamp get exercised.
    function automatic logic [23:0] pick_colour();
        logic [23:0] c;
        c = 24'($urandom);
        case ($urandom_range(0, 9))
            0, 1, 2: c = {8'($urandom_range(8'hF0, 8'hFF)), 8'($urandom_range(8'hF0, 8'hFF)),
                          8'($urandom_range(8'hF0, 8'hFF))};
            3:       c = '0;
            4:       c[8*$urandom_range(0, 2) +: 8] = 8'($urandom_range(8'hF0, 8'hFF));
            5:       c = {8'($urandom_range(8'hE8, 8'hFF)), 8'($urandom_range(8'hE8, 8'hFF)),
                          8'($urandom_range(8'hE8, 8'hFF))};
            default: ;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] pick_timed_code();
        return 8'($urandom_range(int'(rgbw_pkg::CMD_TIMED_BASE) + 1, 255));
    endfunction

    task automatic send_random_request();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 35) begin
            send_request(rgbw_pkg::KIND_FADE_TICK, 8'($urandom), 24'($urandom));
        end else if (sel < 43) begin
            send_request(rgbw_pkg::KIND_NIGHT_TICK, 8'($urandom), 24'($urandom));
        end else if (sel < 90) begin
            case ($urandom_range(0, 6))
                0: send_command(rgbw_pkg::CMD_TOGGLE);
                1: send_command(rgbw_pkg::CMD_ON);
                2: send_command(rgbw_pkg::CMD_OFF);
                3: send_command(rgbw_pkg::CMD_UP);
                4: send_command(rgbw_pkg::CMD_DOWN);
                5: send_request(rgbw_pkg::KIND_CMD, rgbw_pkg::CMD_SET, pick_colour());
                default: send_command(pick_timed_code());
            endcase
        end else begin
            // noise: any kind, any code, any data
            send_request(2'($urandom_range(0, 3)), 8'($urandom), 24'($urandom));
        end
    endtask

    // Good-night run: timed command, then mostly night ticks with fades mixed
    // in; now and then a stray random request breaks the sequence.
    task automatic send_night_run();
        int n;
        int sel;
        send_command(pick_timed_code());
        n = $urandom_range(3, 20);
        repeat (n) begin
            sel = $urandom_range(0, 99);
            if (sel < 65)
                send_request(rgbw_pkg::KIND_NIGHT_TICK, 8'($urandom), 24'($urandom));
            else if (sel < 92)
                send_request(rgbw_pkg::KIND_FADE_TICK, 8'($urandom), 24'($urandom));
            else
                send_random_request();
        end
    endtask

    task automatic send_fade_run();
        repeat ($urandom_range(5, 30))
            send_request(rgbw_pkg::KIND_FADE_TICK, 8'($urandom), 24'($urandom));
    endtask

    // One register setting followed by a burst of random traffic.
    task automatic run_phase(logic [6:0] step, rgbw_pkg::t_level dflt,
                             rgbw_pkg::t_level maxb, rgbw_pkg::t_level minb,
                             int n_requests);
        int first;
        int sel;
        drain_results();
        program_all(step, dflt, maxb, minb);
        first = requests_sent;
        while (requests_sent - first < n_requests) begin
            if ($urandom_range(0, 9) == 0) begin
                sender_eager   = ($urandom_range(0, 2) == 0);
                receiver_eager = ($urandom_range(0, 2) == 0);
            end
            sel = $urandom_range(0, 99);
            if (sel < 15)      send_night_run();
            else if (sel < 25) send_fade_run();
            else               send_random_request();
        end
        sender_eager   = 1'b0;
        receiver_eager = 1'b0;
    endtask

    // -----------------------------------------------------------------------
    // Tests
    // -----------------------------------------------------------------------
    // Requests the block must ignore still report the reset state.
    task automatic test_ignored_requests();
        send_command(CMD_NONE);
        send_command(CMD_FLASH);                  // flash, not supported
        send_command(rgbw_pkg::CMD_TIMED_BASE);   // timed needs a code above the base
        send_request(KIND_UNUSED, rgbw_pkg::CMD_ON, 24'hFFFFFF);
        send_request(rgbw_pkg::KIND_FADE_TICK, 8'hFF, 24'hFFFFFF);
    endtask

    task automatic test_lamp_commands();
        send_command(rgbw_pkg::CMD_ON);           // empty colour turns into white
        send_request(rgbw_pkg::KIND_FADE_TICK, '0, '0);
        send_request(rgbw_pkg::KIND_FADE_TICK, '0, '0);
        send_command(rgbw_pkg::CMD_UP);
        send_command(rgbw_pkg::CMD_DOWN);
        send_colour(8'hFF, 8'h00, 8'h80);         // colour applied raw, at once
        send_command(rgbw_pkg::CMD_UP);           // refade hits the clamp
        send_request(rgbw_pkg::KIND_FADE_TICK, '0, '0);
        send_colour(8'hF0, 8'hFF, 8'hF0);         // just white
        send_command(rgbw_pkg::CMD_TOGGLE);       // on -> off
        send_command(rgbw_pkg::CMD_TOGGLE);       // off -> on
        send_command(rgbw_pkg::CMD_OFF);
        send_colour(8'h00, 8'h00, 8'h00);         // zero colour is not white
        send_command(rgbw_pkg::CMD_DOWN);
    endtask

    task automatic test_good_night();
        send_command(rgbw_pkg::CMD_ON);
        send_command(CMD_TIMED_FIRST);
        send_command(rgbw_pkg::CMD_TOGGLE);       // no effect in good-night
        send_command(CMD_TIMED_LAST);
        repeat (3) send_request(rgbw_pkg::KIND_NIGHT_TICK, '0, '0);
    endtask

    // Each register at a high and a low value, read back, then back to reset values.
    task automatic test_register_access();
        drain_results();
        program_all(7'd64, 8'd255, 8'd255, 8'd255);
        program_all(7'd1, 8'd0, 8'd0, 8'd0);
        program_all(rgbw_pkg::BRIGHT_STEP_RST, rgbw_pkg::BRIGHT_DEFAULT_RST,
                    rgbw_pkg::MAX_BRIGHT_RST, rgbw_pkg::MIN_BRIGHT_RST);
    endtask

    task automatic test_random_traffic();
        run_phase(rgbw_pkg::BRIGHT_STEP_RST, rgbw_pkg::BRIGHT_DEFAULT_RST,
                  rgbw_pkg::MAX_BRIGHT_RST, rgbw_pkg::MIN_BRIGHT_RST, 130);
        run_phase(7'd1, 8'd0, 8'd255, 8'd0, 130);
        run_phase(7'd64, 8'd255, 8'd255, 8'd255, 130);
        run_phase(7'd64, 8'd255, 8'd0, 8'd0, 130);
        run_phase(7'($urandom_range(1, 64)), 8'($urandom), 8'($urandom),
                  8'($urandom_range(0, 80)), 130);
        run_phase(7'($urandom_range(1, 64)), 8'($urandom), 8'($urandom),
                  8'($urandom), 130);
    endtask

    // -----------------------------------------------------------------------
    // Main sequence
    // -----------------------------------------------------------------------
    initial begin
        lamp_model_reset();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_ignored_requests();
        test_lamp_commands();
        test_good_night();
        test_register_access();
        test_random_traffic();

        drain_results();
        repeat (8) @(posedge i_clk);
        if (fault_count == 0)
            $display("** rgbw_lamp_fade_controller_top: PASSED **");
        else
            $display("** rgbw_lamp_fade_controller_top: FAILED **");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #2000000;
        $display("** rgbw_lamp_fade_controller_top: FAILED **");
        $finish;
    end

endmodule
